[src/button_gesture_detector_defines.svh]
// Assertion macros for the button gesture detector.
// Used by the top level only; expects clk and rst in scope.
`ifndef BUTTON_GESTURE_DETECTOR_DEFINES_SVH
`define BUTTON_GESTURE_DETECTOR_DEFINES_SVH

// Antecedent true at an edge implies consequent at that same edge.
`define BGD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent true at an edge implies consequent at the next edge.
`define BGD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/bgd_pkg.sv]
// Shared types, constants and timer helpers for the button gesture detector.
// No dependencies.
package bgd_pkg;

  localparam int TIMER_W = 16;
  localparam int CFG_W   = 16;
  localparam int CMP_W   = (TIMER_W > CFG_W) ? TIMER_W : CFG_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE   = 2'd2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd20;
  localparam logic [CFG_W-1:0] LONG_RST     = 16'd800;
  localparam logic [CFG_W-1:0] DOUBLE_RST   = 16'd400;

  typedef enum logic [1:0] {
    GEST_NONE   = 2'd0,
    GEST_SINGLE = 2'd1,
    GEST_DOUBLE = 2'd2,
    GEST_LONG   = 2'd3
  } gesture_t;

  // accepted debounced edges for one word
  typedef struct packed {
    logic press;
    logic lift;
  } bgd_edge_t;

  function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] v);
    return (v == TIMER_MAX) ? v : v + 1'b1;
  endfunction

  // unsigned timer >= threshold, both widened to a common width
  function automatic logic timer_ge(input logic [TIMER_W-1:0] t,
                                    input logic [CFG_W-1:0] c);
    return CMP_W'(t) >= CMP_W'(c);
  endfunction

  function automatic logic timer_gt(input logic [TIMER_W-1:0] t,
                                    input logic [CFG_W-1:0] c);
    return CMP_W'(t) > CMP_W'(c);
  endfunction

endpackage

[src/button_gesture_detector.sv]
// Top level of the button gesture detector: config registers, result register.
// Depends on bgd_pkg, bgd_debounce, bgd_gesture and the defines header.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------
//  sample   | sample_valid/sample_ready  | button_level
//  result   | result_valid/result_ready  | gesture, red_on, green_on, stable_level
//  cfg      | cfg_valid/cfg_ready        | cfg_index, cfg_data
//
// One sample word in, one result word out; the result word is registered.
// A new sample is taken every cycle while the result register is empty or
// being drained in the same cycle; throughput is one word per clock.
// Detector state updates only on an accepted sample; a stalled result holds.
// rst (synchronous) restores the config defaults 20/800/400 and clears state.
// cfg_ready is always high; index 3 is ignored.
`include "button_gesture_detector_defines.svh"

module button_gesture_detector (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  logic                          button_level,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [1:0]                    gesture,
  output logic                          red_on,
  output logic                          green_on,
  output logic                          stable_level,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bgd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bgd_pkg::CFG_W-1:0]     cfg_data
);
  import bgd_pkg::*;

  logic [CFG_W-1:0] debounce_ticks;
  logic [CFG_W-1:0] long_press_ticks;
  logic [CFG_W-1:0] double_click_ticks;

  logic      accept;
  bgd_edge_t edges;
  logic      level_next;
  gesture_t  gesture_next;
  logic      red_next;
  logic      green_next;

  assign cfg_ready    = 1'b1;
  // result register frees up when drained this cycle
  assign sample_ready = !result_valid || result_ready;
  assign accept       = sample_valid && sample_ready;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks     <= DEBOUNCE_RST;
      long_press_ticks   <= LONG_RST;
      double_click_ticks <= DOUBLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEBOUNCE: debounce_ticks     <= cfg_data;
        CFG_LONG:     long_press_ticks   <= cfg_data;
        CFG_DOUBLE:   double_click_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  bgd_debounce u_debounce (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .raw            (button_level),
    .debounce_ticks (debounce_ticks),
    .edges          (edges),
    .level_next     (level_next)
  );

  bgd_gesture u_gesture (
    .clk                (clk),
    .rst                (rst),
    .accept             (accept),
    .edges              (edges),
    .long_press_ticks   (long_press_ticks),
    .double_click_ticks (double_click_ticks),
    .gesture_next       (gesture_next),
    .red_next           (red_next),
    .green_next         (green_next)
  );

  // result register; payload reset too so status never shows X
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      gesture      <= GEST_NONE;
      red_on       <= 1'b0;
      green_on     <= 1'b0;
      stable_level <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
      gesture      <= gesture_next;
      red_on       <= red_next;
      green_on     <= green_next;
      stable_level <= level_next;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  `BGD_ASSERT_SAME(a_no_overwrite, result_valid && !result_ready, !sample_ready, "sample taken over a stalled result")
  `BGD_ASSERT_NEXT(a_result_follows, accept, result_valid, "accepted sample produced no result")
  `BGD_ASSERT_SAME(a_single_lamps, result_valid && (gesture == GEST_SINGLE), red_on && !green_on, "single click lamp mismatch")
  `BGD_ASSERT_SAME(a_long_lamps, result_valid && (gesture == GEST_LONG), !red_on && !green_on, "long press lamp mismatch")

endmodule

[src/bgd_debounce.sv]
// Debounce stage: settle counter and debounced level.
// Depends on bgd_pkg.
module bgd_debounce (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic                      raw,
  input  logic [bgd_pkg::CFG_W-1:0] debounce_ticks,
  output bgd_pkg::bgd_edge_t        edges,
  output logic                      level_next
);
  import bgd_pkg::*;

  logic               previous_raw;
  logic               debounced_level;
  logic [TIMER_W-1:0] settle_count;
  logic [TIMER_W-1:0] settle_count_next;
  logic               take;

  always_comb begin
    settle_count_next = (raw != previous_raw) ? '0 : sat_inc(settle_count);
    take = timer_gt(settle_count_next, debounce_ticks) && (raw != debounced_level);
    edges.press = take && raw;
    edges.lift  = take && !raw;
    level_next  = take ? raw : debounced_level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_raw    <= 1'b0;
      debounced_level <= 1'b0;
      settle_count    <= '0;
    end else if (accept) begin
      previous_raw    <= raw;
      debounced_level <= level_next;
      settle_count    <= settle_count_next;
    end
  end

endmodule

[src/bgd_gesture.sv]
// Gesture recognizer: long press, double click and single click, lamp state.
// Depends on bgd_pkg; fed by bgd_debounce edges.
module bgd_gesture (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  bgd_pkg::bgd_edge_t        edges,
  input  logic [bgd_pkg::CFG_W-1:0] long_press_ticks,
  input  logic [bgd_pkg::CFG_W-1:0] double_click_ticks,
  output bgd_pkg::gesture_t         gesture_next,
  output logic                      red_next,
  output logic                      green_next
);
  import bgd_pkg::*;

  logic               held, held_next;
  logic [TIMER_W-1:0] hold_count, hold_count_next;
  logic               long_fired, long_fired_next;
  logic               awaiting_second, awaiting_second_next;
  logic [TIMER_W-1:0] window_count, window_count_next;
  logic               double_pending, double_pending_next;
  logic               red_lamp, green_lamp;

  always_comb begin
    held_next            = held;
    hold_count_next      = sat_inc(hold_count);
    long_fired_next      = long_fired;
    awaiting_second_next = awaiting_second;
    window_count_next    = sat_inc(window_count);
    double_pending_next  = double_pending;
    red_next             = red_lamp;
    green_next           = green_lamp;
    gesture_next         = GEST_NONE;

    if (edges.press) begin
      held_next       = 1'b1;
      hold_count_next = '0;
      if (awaiting_second) begin
        awaiting_second_next = 1'b0;
        double_pending_next  = 1'b1;
      end
    end
    if (edges.lift) begin
      held_next = 1'b0;
      if (!timer_ge(hold_count_next, long_press_ticks)) begin
        if (double_pending) begin
          gesture_next        = GEST_DOUBLE;
          red_next            = 1'b0;
          green_next          = 1'b1;
          double_pending_next = 1'b0;
        end else begin
          awaiting_second_next = 1'b1;
          window_count_next    = '0;
        end
      end
    end

    if (held_next && !long_fired && timer_ge(hold_count_next, long_press_ticks)) begin
      gesture_next         = GEST_LONG;
      red_next             = 1'b0;
      green_next           = 1'b0;
      long_fired_next      = 1'b1;
      awaiting_second_next = 1'b0;
      double_pending_next  = 1'b0;
    end

    if (!held_next && awaiting_second_next &&
        timer_ge(window_count_next, double_click_ticks)) begin
      gesture_next         = GEST_SINGLE;
      red_next             = 1'b1;
      green_next           = 1'b0;
      awaiting_second_next = 1'b0;
    end

    if (!held_next) begin
      long_fired_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held            <= 1'b0;
      hold_count      <= '0;
      long_fired      <= 1'b0;
      awaiting_second <= 1'b0;
      window_count    <= '0;
      double_pending  <= 1'b0;
      red_lamp        <= 1'b0;
      green_lamp      <= 1'b0;
    end else if (accept) begin
      held            <= held_next;
      hold_count      <= hold_count_next;
      long_fired      <= long_fired_next;
      awaiting_second <= awaiting_second_next;
      window_count    <= window_count_next;
      double_pending  <= double_pending_next;
      red_lamp        <= red_next;
      green_lamp      <= green_next;
    end
  end

endmodule

[verif/button_gesture_detector_test.sv]
// Self-checking testbench for button_gesture_detector: directed gestures, full-scale
// thresholds and long random gesture mixes under random idling on both sides.
// Depends on bgd_pkg and the button_gesture_detector RTL.
module button_gesture_detector_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bgd_pkg::*;

  // index 3 has no register behind it; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // what one result word should look like
  typedef struct packed {
    gesture_t gesture;
    logic     red;
    logic     green;
    logic     stable;
  } lamp_word_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 sample_valid = 1'b0;
  logic                 sample_ready;
  logic                 button_level = 1'b0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  logic [1:0]           gesture;
  logic                 red_on;
  logic                 green_on;
  logic                 stable_level;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  button_gesture_detector dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .button_level (button_level),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .gesture      (gesture),
    .red_on       (red_on),
    .green_on     (green_on),
    .stable_level (stable_level),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow copy of the detector: thresholds plus every piece of state.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0]   debounce_limit;
  logic [CFG_W-1:0]   long_limit;
  logic [CFG_W-1:0]   double_limit;
  logic               raw_prev;
  logic               level_q;
  logic [TIMER_W-1:0] settle_ticks;
  logic               pressed;
  logic [TIMER_W-1:0] hold_ticks;
  logic               long_done;
  logic               window_open;
  logic [TIMER_W-1:0] window_ticks;
  logic               second_press;
  logic               red_q;
  logic               green_q;

  lamp_word_t expected_words[$];
  lamp_word_t head_word;

  int mismatch_count = 0;
  int samples_sent = 0;
  int burst_left = 0;
  int ready_left = 0;
  bit idle_on = 1'b1;   // cleared for stretches with no idling on either side

  function automatic logic [TIMER_W-1:0] count_up(input logic [TIMER_W-1:0] v);
    return (v == {TIMER_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  // One tick of the recognizer for an accepted sample word; queues the result.
  task automatic advance_detector(input logic raw);
    gesture_t   g;
    lamp_word_t w;
    g = GEST_NONE;
    hold_ticks   = count_up(hold_ticks);
    window_ticks = count_up(window_ticks);
    // any change of the raw level restarts the settle timer
    if (raw != raw_prev) settle_ticks = '0;
    else settle_ticks = count_up(settle_ticks);

    if (settle_ticks > debounce_limit && raw != level_q) begin
      level_q = raw;
      if (raw) begin
        pressed    = 1'b1;
        hold_ticks = '0;
        // a press inside the window arms the double click
        if (window_open) begin
          window_open  = 1'b0;
          second_press = 1'b1;
        end
      end else begin
        pressed = 1'b0;
        // release after a long hold is swallowed
        if (hold_ticks < long_limit) begin
          if (second_press) begin
            g            = GEST_DOUBLE;
            red_q        = 1'b0;
            green_q      = 1'b1;
            second_press = 1'b0;
          end else begin
            window_open  = 1'b1;
            window_ticks = '0;
          end
        end
      end
    end
    raw_prev = raw;

    // long press fires while still held, once per press
    if (pressed && !long_done && hold_ticks >= long_limit) begin
      g            = GEST_LONG;
      red_q        = 1'b0;
      green_q      = 1'b0;
      long_done    = 1'b1;
      window_open  = 1'b0;
      second_press = 1'b0;
    end

    if (!pressed && window_open && window_ticks >= double_limit) begin
      g           = GEST_SINGLE;
      red_q       = 1'b1;
      green_q     = 1'b0;
      window_open = 1'b0;
    end

    if (!pressed) long_done = 1'b0;

    w.gesture = g;
    w.red     = red_q;
    w.green   = green_q;
    w.stable  = level_q;
    expected_words.push_back(w);
  endtask

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    // keep the log bounded if the block goes badly wrong
    if (mismatch_count <= 100) $display("%0t mismatch: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stall pattern and the checker.
  // ---------------------------------------------------------------------------
  // Ready alternates between short stalls and longer open stretches.
  always @(negedge clk) begin
    if (!idle_on) begin
      result_ready <= 1'b1;
    end else if (ready_left == 0) begin
      if (result_ready) begin
        result_ready <= 1'b0;
        ready_left = $urandom_range(0, 5);
      end else begin
        result_ready <= 1'b1;
        ready_left = $urandom_range(0, 15);
      end
    end else begin
      ready_left--;
    end
  end

  // Every result word is matched against the oldest queued expectation.
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && result_ready) begin
      if (expected_words.size() == 0) begin
        flag_mismatch("result word with nothing pending");
      end else begin
        head_word = expected_words.pop_front();
        if (gesture !== head_word.gesture)
          flag_mismatch($sformatf("gesture %0d, want %0d", gesture, head_word.gesture));
        if (red_on !== head_word.red)
          flag_mismatch($sformatf("red_on %b, want %b", red_on, head_word.red));
        if (green_on !== head_word.green)
          flag_mismatch($sformatf("green_on %b, want %b", green_on, head_word.green));
        if (stable_level !== head_word.stable)
          flag_mismatch($sformatf("stable_level %b, want %b", stable_level,
                                  head_word.stable));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sample side.
  // ---------------------------------------------------------------------------
  // Sends one sample word. The sender runs in bursts; between bursts valid
  // drops for a random gap. Valid stays high after acceptance so
  // back-to-back words need no extra edge.
  task automatic send_sample(input logic level);
    int gap;
    if (idle_on && burst_left == 0) begin
      gap        = $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      @(negedge clk);
      sample_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    sample_valid <= 1'b1;
    button_level <= level;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    samples_sent++;
    advance_detector(level);
  endtask

  task automatic hold_level(input logic level, input int count);
    for (int i = 0; i < count; i++) send_sample(level);
  endtask

  // random bouncing
  task automatic chatter(input int count);
    for (int i = 0; i < count; i++) send_sample(1'($urandom_range(0, 1)));
  endtask

  // Sender goes quiet until every queued result has come back.
  task automatic wait_for_drain();
    int waited;
    waited = 0;
    if (sample_valid) begin
      @(negedge clk);
      sample_valid <= 1'b0;
    end
    while (expected_words.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (3) @(posedge clk);
  endtask

  // Only called with the sample side idle and nothing outstanding.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_DEBOUNCE: debounce_limit = data;
      CFG_LONG:     long_limit     = data;
      CFG_DOUBLE:   double_limit   = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------
  task automatic test_directed_gestures();
    // reset thresholds: a short bounce never gets through the debouncer
    send_sample(1'b1);
    send_sample(1'b0);
    send_sample(1'b1);
    wait_for_drain();
    write_register(CFG_DEBOUNCE, 16'd0);
    write_register(CFG_LONG, 16'd0);
    write_register(CFG_DOUBLE, 16'd0);
    write_register(CFG_UNUSED, 16'hFFFF);
    // zero hold threshold: long press on the very tick of the press edge
    hold_level(1'b1, 2);
    hold_level(1'b0, 2);
    wait_for_drain();
    write_register(CFG_LONG, 16'd4);
    // zero window: single click on the release edge itself
    hold_level(1'b1, 2);
    hold_level(1'b0, 2);
    wait_for_drain();
    write_register(CFG_DOUBLE, 16'd3);
    // double click, then a single click once the window runs out
    hold_level(1'b1, 2);
    hold_level(1'b0, 2);
    hold_level(1'b1, 2);
    hold_level(1'b0, 2);
    hold_level(1'b1, 2);
    hold_level(1'b0, 5);
  endtask

  // All-ones thresholds: the settle compare can never pass, so the debounced
  // level stays put however long the opposite level is held.
  task automatic test_full_scale_thresholds();
    wait_for_drain();
    write_register(CFG_DEBOUNCE, 16'hFFFF);
    write_register(CFG_LONG, 16'hFFFF);
    write_register(CFG_DOUBLE, 16'hFFFF);
    hold_level(~level_q, 40);
    wait_for_drain();
  endtask

  // One gesture-shaped run of samples, lengths chosen around the thresholds.
  task automatic play_gesture(input int deb, input int lng, input int dbl);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7 && $urandom_range(0, 1)) chatter($urandom_range(1, deb + 1));
    case (pick)
      0, 1, 2: begin
        // single click
        hold_level(1'b1, deb + 1 + $urandom_range(1, lng / 2 + 1));
        hold_level(1'b0, deb + 1 + dbl + $urandom_range(0, 6));
      end
      3, 4: begin
        // double click, second release sometimes near the window edge
        hold_level(1'b1, deb + 1 + $urandom_range(1, lng / 2 + 1));
        hold_level(1'b0, deb + 1 + $urandom_range(1, dbl / 2 + 2));
        if ($urandom_range(0, 1)) chatter($urandom_range(1, deb + 1));
        hold_level(1'b1, deb + 1 + $urandom_range(1, lng / 2 + 1));
        hold_level(1'b0, deb + 1 + dbl + $urandom_range(0, 6));
      end
      5, 6: begin
        // long press
        hold_level(1'b1, deb + 1 + lng + $urandom_range(0, 8));
        hold_level(1'b0, deb + 2 + $urandom_range(0, dbl));
      end
      7: chatter($urandom_range(1, 3 * deb + 4));
      8: begin
        // press too short to pass the debouncer
        hold_level(1'b1, $urandom_range(1, deb + 1));
        hold_level(1'b0, $urandom_range(1, deb + dbl + 2));
      end
      default: hold_level(1'($urandom_range(0, 1)), $urandom_range(1, deb + lng + dbl + 4));
    endcase
  endtask

  task automatic test_random_gestures();
    int               deb;
    int               lng;
    int               dbl;
    int               start;
    int               phase_end;
    logic [CFG_W-1:0] vals [3];
    for (int phase = 0; phase < 7; phase++) begin
      wait_for_drain();
      // one phase runs with no idling at all
      idle_on = (phase != 3);
      deb = (phase == 0) ? 0 : $urandom_range(0, 4);
      lng = (phase == 1) ? 0 : $urandom_range(1, 24);
      dbl = (phase == 2) ? 0 : $urandom_range(1, 20);
      vals[CFG_DEBOUNCE] = CFG_W'(deb);
      vals[CFG_LONG]     = CFG_W'(lng);
      vals[CFG_DOUBLE]   = CFG_W'(dbl);
      start = $urandom_range(0, 2);
      for (int k = 0; k < 3; k++)
        write_register(CFG_IDX_W'((start + k) % 3), vals[(start + k) % 3]);
      if ($urandom_range(0, 2) == 0) write_register(CFG_UNUSED, CFG_W'($urandom));
      phase_end = samples_sent + 150;
      while (samples_sent < phase_end) begin
        play_gesture(deb, lng, dbl);
        // now and then let the pipeline run dry mid-phase
        if ($urandom_range(0, 19) == 0) wait_for_drain();
      end
    end
    idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // shadow state matches the block's reset
    debounce_limit = DEBOUNCE_RST;
    long_limit     = LONG_RST;
    double_limit   = DOUBLE_RST;
    raw_prev       = 1'b0;
    level_q        = 1'b0;
    settle_ticks   = '0;
    pressed        = 1'b0;
    hold_ticks     = '0;
    long_done      = 1'b0;
    window_open    = 1'b0;
    window_ticks   = '0;
    second_press   = 1'b0;
    red_q          = 1'b0;
    green_q        = 1'b0;

    test_directed_gestures();
    test_full_scale_thresholds();
    test_random_gestures();

    wait_for_drain();
    if (expected_words.size() != 0)
      flag_mismatch($sformatf("%0d result words never arrived", expected_words.size()));
    if (mismatch_count == 0) begin
      $display("PASS button_gesture_detector");
    end else begin
      $display("FAIL button_gesture_detector");
    end
    $finish;
  end

  // watchdog: several times the slowest legal run
  initial begin
    #4000000;
    $display("FAIL button_gesture_detector");
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/bgd_pkg.sv
src/bgd_debounce.sv
src/bgd_gesture.sv
src/button_gesture_detector.sv
verif/button_gesture_detector_test.sv
